// ===== hw/rtl/rdbi_pkg.sv =====
// types, constants and microprogram for the degree-4 base inversion block
package rdbi_pkg;

  localparam int LEAF_COUNT = 192;
  localparam int LEAF_AW    = (LEAF_COUNT > 1) ? $clog2(LEAF_COUNT) : 1;

  localparam int unsigned Q        = 3457;
  localparam int unsigned HALF_Q   = Q / 2;
  localparam int unsigned RINV     = 2775;
  localparam int unsigned SCALE    = 3310;
  localparam int unsigned EXP_BITS = 12;
  localparam int unsigned EXP      = Q - 2;
  localparam int unsigned BARRETT  = (1 << 24) / Q;
  localparam int unsigned COEF_BIAS = 10 * Q;

  localparam int PC_W = 7;
  localparam logic [PC_W-1:0] PROG_LAST = PC_W'(65);

  typedef struct packed {
    logic               command;
    logic [7:0]         leaf_index;
    logic signed [15:0] coef_zero;
    logic signed [15:0] coef_one;
    logic signed [15:0] coef_two;
    logic signed [15:0] coef_three;
    logic [11:0]        root_mont;
  } rdbi_in_t;

  typedef struct packed {
    logic signed [11:0] out_zero;
    logic signed [11:0] out_one;
    logic signed [11:0] out_two;
    logic signed [11:0] out_three;
    logic               leaf_failed;
    logic               batch_failed;
  } rdbi_out_t;

  typedef enum logic {
    CMD_INVERT = 1'b0,
    CMD_READ   = 1'b1
  } rdbi_cmd_e;

  typedef enum logic [1:0] {
    OP_LD  = 2'd0,
    OP_MUL = 2'd1,
    OP_ADD = 2'd2,
    OP_SUB = 2'd3
  } rdbi_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ISSUE,
    ST_EX1,
    ST_EX2,
    ST_EX3,
    ST_RDMEM,
    ST_DONE
  } rdbi_state_e;

  typedef struct packed {
    rdbi_op_e    op;
    logic [3:0]  dst;
    logic [3:0]  ra;
    logic [3:0]  rb;
    logic        imm_a;
    logic        imm_b;
    logic [11:0] imm;
    logic        tst;
    logic        res;
  } rdbi_instr_t;

  typedef struct packed {
    logic            ld_in;
    logic            rf_rd;
    logic            ex1;
    logic            ex2;
    logic            ex3;
    logic            mem_rd;
    logic            finish;
    logic [PC_W-1:0] pc;
  } rdbi_cmd_t;

  typedef struct packed {
    logic is_read;
  } rdbi_sts_t;

  // register file slots
  localparam logic [3:0] R_A0  = 4'd0;
  localparam logic [3:0] R_A1  = 4'd1;
  localparam logic [3:0] R_A2  = 4'd2;
  localparam logic [3:0] R_A3  = 4'd3;
  localparam logic [3:0] R_LAM = 4'd4;
  localparam logic [3:0] R_T0  = 4'd5;
  localparam logic [3:0] R_T1  = 4'd6;
  localparam logic [3:0] R_B   = 4'd7;
  localparam logic [3:0] R_ACC = 4'd8;
  localparam logic [3:0] R_X   = 4'd9;
  localparam logic [3:0] R_Y   = 4'd10;
  localparam logic [3:0] R_N0  = 4'd12;
  localparam logic [3:0] R_N1  = 4'd13;
  localparam logic [3:0] R_N2  = 4'd14;
  localparam logic [3:0] R_N3  = 4'd15;

  // load source selectors
  localparam logic [3:0] SRC_C0  = 4'd0;
  localparam logic [3:0] SRC_C1  = 4'd1;
  localparam logic [3:0] SRC_C2  = 4'd2;
  localparam logic [3:0] SRC_C3  = 4'd3;
  localparam logic [3:0] SRC_LAM = 4'd4;

  function automatic rdbi_instr_t ins(rdbi_op_e op, logic [3:0] d, logic [3:0] a,
                                      logic [3:0] b, logic ia, logic ib,
                                      logic [11:0] k, logic t, logic r);
    rdbi_instr_t i;
    i.op = op; i.dst = d; i.ra = a; i.rb = b;
    i.imm_a = ia; i.imm_b = ib; i.imm = k; i.tst = t; i.res = r;
    return i;
  endfunction

  function automatic rdbi_instr_t rr(rdbi_op_e op, logic [3:0] d, logic [3:0] a,
                                     logic [3:0] b);
    return ins(op, d, a, b, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0);
  endfunction

  function automatic rdbi_instr_t ldi(logic [3:0] d, logic [3:0] s);
    return ins(OP_LD, d, s, 4'd0, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0);
  endfunction

  function automatic rdbi_instr_t neg(logic [3:0] d, logic [3:0] b);
    return ins(OP_SUB, d, 4'd0, b, 1'b1, 1'b0, 12'd0, 1'b0, 1'b0);
  endfunction

  function automatic rdbi_instr_t rdbi_prog(logic [PC_W-1:0] pc);
    rdbi_instr_t i;
    case (pc)
      7'd0:  i = ldi(R_A0, SRC_C0);
      7'd1:  i = ldi(R_A1, SRC_C1);
      7'd2:  i = ldi(R_A2, SRC_C2);
      7'd3:  i = ldi(R_A3, SRC_C3);
      7'd4:  i = ldi(R_LAM, SRC_LAM);
      7'd5:  i = ins(OP_MUL, R_LAM, R_LAM, 4'd0, 1'b0, 1'b1, 12'(RINV), 1'b0, 1'b0);
      // t0
      7'd6:  i = rr(OP_MUL, R_X, R_A2, R_A2);
      7'd7:  i = rr(OP_MUL, R_Y, R_A1, R_A3);
      7'd8:  i = rr(OP_SUB, R_X, R_X, R_Y);
      7'd9:  i = rr(OP_SUB, R_X, R_X, R_Y);
      7'd10: i = rr(OP_MUL, R_X, R_LAM, R_X);
      7'd11: i = rr(OP_MUL, R_Y, R_A0, R_A0);
      7'd12: i = rr(OP_ADD, R_T0, R_Y, R_X);
      // t1
      7'd13: i = rr(OP_MUL, R_X, R_A3, R_A3);
      7'd14: i = rr(OP_MUL, R_X, R_LAM, R_X);
      7'd15: i = rr(OP_MUL, R_Y, R_A1, R_A1);
      7'd16: i = rr(OP_ADD, R_X, R_X, R_Y);
      7'd17: i = rr(OP_MUL, R_Y, R_A0, R_A2);
      7'd18: i = rr(OP_SUB, R_X, R_X, R_Y);
      7'd19: i = rr(OP_SUB, R_T1, R_X, R_Y);
      // determinant
      7'd20: i = rr(OP_MUL, R_X, R_T1, R_T1);
      7'd21: i = rr(OP_MUL, R_X, R_LAM, R_X);
      7'd22: i = rr(OP_MUL, R_Y, R_T0, R_T0);
      7'd23: i = ins(OP_SUB, R_B, R_Y, R_X, 1'b0, 1'b0, 12'd0, 1'b1, 1'b0);
      // inverse by square and multiply, exponent bits lsb first
      7'd24: i = ins(OP_ADD, R_ACC, R_B, 4'd0, 1'b0, 1'b1, 12'd0, 1'b0, 1'b0);
      7'd25: i = rr(OP_MUL, R_B, R_B, R_B);
      7'd26: i = rr(OP_MUL, R_ACC, R_ACC, R_B);
      7'd27: i = rr(OP_MUL, R_B, R_B, R_B);
      7'd28: i = rr(OP_MUL, R_ACC, R_ACC, R_B);
      7'd29: i = rr(OP_MUL, R_B, R_B, R_B);
      7'd30: i = rr(OP_MUL, R_ACC, R_ACC, R_B);
      7'd31: i = rr(OP_MUL, R_B, R_B, R_B);
      7'd32: i = rr(OP_MUL, R_ACC, R_ACC, R_B);
      7'd33: i = rr(OP_MUL, R_B, R_B, R_B);
      7'd34: i = rr(OP_MUL, R_ACC, R_ACC, R_B);
      7'd35: i = rr(OP_MUL, R_B, R_B, R_B);
      7'd36: i = rr(OP_MUL, R_ACC, R_ACC, R_B);
      7'd37: i = rr(OP_MUL, R_B, R_B, R_B);
      7'd38: i = rr(OP_MUL, R_B, R_B, R_B);
      7'd39: i = rr(OP_MUL, R_ACC, R_ACC, R_B);
      7'd40: i = rr(OP_MUL, R_B, R_B, R_B);
      7'd41: i = rr(OP_MUL, R_B, R_B, R_B);
      7'd42: i = rr(OP_MUL, R_ACC, R_ACC, R_B);
      7'd43: i = rr(OP_MUL, R_B, R_B, R_B);
      7'd44: i = rr(OP_MUL, R_ACC, R_ACC, R_B);
      7'd45: i = ins(OP_MUL, R_ACC, R_ACC, 4'd0, 1'b0, 1'b1, 12'(SCALE), 1'b0, 1'b0);
      // numerators
      7'd46: i = rr(OP_MUL, R_X, R_A2, R_T1);
      7'd47: i = rr(OP_MUL, R_X, R_LAM, R_X);
      7'd48: i = rr(OP_MUL, R_Y, R_A0, R_T0);
      7'd49: i = rr(OP_ADD, R_N0, R_Y, R_X);
      7'd50: i = rr(OP_MUL, R_X, R_A3, R_T1);
      7'd51: i = rr(OP_MUL, R_X, R_LAM, R_X);
      7'd52: i = rr(OP_MUL, R_Y, R_A1, R_T0);
      7'd53: i = rr(OP_ADD, R_X, R_X, R_Y);
      7'd54: i = neg(R_N1, R_X);
      7'd55: i = rr(OP_MUL, R_X, R_A2, R_T0);
      7'd56: i = rr(OP_MUL, R_Y, R_A0, R_T1);
      7'd57: i = rr(OP_ADD, R_N2, R_X, R_Y);
      7'd58: i = rr(OP_MUL, R_X, R_A1, R_T1);
      7'd59: i = rr(OP_MUL, R_Y, R_A3, R_T0);
      7'd60: i = rr(OP_ADD, R_X, R_X, R_Y);
      7'd61: i = neg(R_N3, R_X);
      // scale by inverse into result lanes
      7'd62: i = ins(OP_MUL, R_N0, R_N0, R_ACC, 1'b0, 1'b0, 12'd0, 1'b0, 1'b1);
      7'd63: i = ins(OP_MUL, R_N1, R_N1, R_ACC, 1'b0, 1'b0, 12'd0, 1'b0, 1'b1);
      7'd64: i = ins(OP_MUL, R_N2, R_N2, R_ACC, 1'b0, 1'b0, 12'd0, 1'b0, 1'b1);
      7'd65: i = ins(OP_MUL, R_N3, R_N3, R_ACC, 1'b0, 1'b0, 12'd0, 1'b0, 1'b1);
      default: i = rr(OP_ADD, R_X, R_X, R_X);
    endcase
    return i;
  endfunction

endpackage

// ===== hw/rtl/ring_degree4_base_inverse.sv =====
// top level of the degree-4 base inversion block
// Inverts one leaf of Z_q[x]/(x^4 - lambda), q = 3457, per invert item and stores it; a read
// item returns a stored leaf. One item is worked at a time. An invert item runs 66 modular
// operations on the single shared modular unit, each as operand read, add or multiply,
// Barrett quotient, correction and write back. The input is stalled while an item is in work;
// the next item is accepted while the previous result still waits in the output register.
module ring_degree4_base_inverse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rdbi_pkg::rdbi_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rdbi_pkg::rdbi_out_t out_data_o
);
  import rdbi_pkg::*;

  rdbi_cmd_t cmd;
  rdbi_sts_t sts;

  rdbi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rdbi_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== hw/rtl/rdbi_dp.sv =====
// datapath: register file, modular unit, leaf store and result register
module rdbi_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rdbi_pkg::rdbi_cmd_t cmd_i,
  output rdbi_pkg::rdbi_sts_t sts_o,
  input  rdbi_pkg::rdbi_in_t  in_data_i,
  output rdbi_pkg::rdbi_out_t out_data_o
);
  import rdbi_pkg::*;

  rdbi_in_t    in_q;
  rdbi_instr_t instr;
  logic [11:0] rf [16];
  logic [11:0] opa_q, opb_q;
  logic [11:0] a_op, b_op;
  logic [23:0] x_d, x_q;
  logic [12:0] qe_q;
  logic [36:0] bprod;
  logic [24:0] rr_val;
  logic [11:0] r_val;
  logic [11:0] res_q [4];
  logic [47:0] mem [LEAF_COUNT];
  logic [47:0] mem_rd_q;
  logic        leaf_fail_q;
  logic        sticky_q, sticky_d;
  logic        in_range;
  logic [LEAF_AW-1:0] addr;
  logic [47:0] res_word;
  logic [47:0] sel_word;
  rdbi_out_t   out_q;

  assign instr    = rdbi_prog(cmd_i.pc);
  assign sts_o.is_read = (in_q.command == CMD_READ);
  assign in_range = (32'(in_q.leaf_index) < LEAF_COUNT);
  assign addr     = LEAF_AW'(in_q.leaf_index);
  assign res_word = {res_q[3], res_q[2], res_q[1], res_q[0]};

  function automatic logic [23:0] coef_load(logic signed [15:0] c);
    logic signed [17:0] s;
    s = 18'(c) + 18'(COEF_BIAS);
    return 24'(s[16:0]);
  endfunction

  function automatic logic [11:0] center(logic [11:0] r);
    logic [12:0] t;
    t = (13'(r) > 13'(HALF_Q)) ? 13'(r) - 13'(Q) : 13'(r);
    return t[11:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      in_q <= in_data_i;
    end
  end

  // register file
  always_ff @(posedge clk_i) begin
    if (cmd_i.rf_rd) begin
      opa_q <= rf[instr.ra];
      opb_q <= rf[instr.rb];
    end
    if (cmd_i.ex3) begin
      rf[instr.dst] <= r_val;
    end
  end

  assign a_op = instr.imm_a ? instr.imm : opa_q;
  assign b_op = instr.imm_b ? instr.imm : opb_q;

  always_comb begin
    case (instr.op)
      OP_LD: begin
        case (instr.ra)
          SRC_C0:  x_d = coef_load(in_q.coef_zero);
          SRC_C1:  x_d = coef_load(in_q.coef_one);
          SRC_C2:  x_d = coef_load(in_q.coef_two);
          SRC_C3:  x_d = coef_load(in_q.coef_three);
          default: x_d = 24'(in_q.root_mont);
        endcase
      end
      OP_MUL:  x_d = 24'(a_op) * 24'(b_op);
      OP_ADD:  x_d = 24'(a_op) + 24'(b_op);
      OP_SUB:  x_d = 24'(a_op) + 24'(Q) - 24'(b_op);
      default: x_d = '0;
    endcase
  end

  assign bprod  = 37'(x_q) * 37'(BARRETT);
  assign rr_val = 25'(x_q) - 25'(qe_q) * 25'(Q);
  assign r_val  = (rr_val >= 25'(Q)) ? 12'(rr_val - 25'(Q)) : rr_val[11:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.ex1) begin
      x_q <= x_d;
    end
    if (cmd_i.ex2) begin
      qe_q <= bprod[36:24];
    end
    if (cmd_i.ex3 && instr.res) begin
      res_q[instr.dst[1:0]] <= center(r_val);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_fail_q <= 1'b0;
      sticky_q    <= 1'b0;
    end else begin
      if (cmd_i.ex3 && instr.tst) begin
        leaf_fail_q <= (r_val == 12'd0);
      end
      if (cmd_i.finish) begin
        sticky_q <= sticky_d;
      end
    end
  end

  always_comb begin
    if (in_q.command == CMD_INVERT) begin
      sticky_d = ((in_q.leaf_index == 8'd0) ? 1'b0 : sticky_q) | leaf_fail_q;
      sel_word = res_word;
    end else begin
      sticky_d = sticky_q;
      sel_word = in_range ? mem_rd_q : '0;
    end
  end

  // leaf store
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd && in_range) begin
      mem_rd_q <= mem[addr];
    end
    if (cmd_i.finish && in_q.command == CMD_INVERT && in_range) begin
      mem[addr] <= res_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.out_zero     <= sticky_d ? '0 : sel_word[11:0];
      out_q.out_one      <= sticky_d ? '0 : sel_word[23:12];
      out_q.out_two      <= sticky_d ? '0 : sel_word[35:24];
      out_q.out_three    <= sticky_d ? '0 : sel_word[47:36];
      out_q.leaf_failed  <= (in_q.command == CMD_INVERT) & leaf_fail_q;
      out_q.batch_failed <= sticky_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== hw/rtl/rdbi_ctrl.sv =====
// controller: sequences the microprogram and the item handshakes
module rdbi_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rdbi_pkg::rdbi_cmd_t cmd_o,
  input  rdbi_pkg::rdbi_sts_t sts_i
);
  import rdbi_pkg::*;

  rdbi_state_e     state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.pc    = pc_q;
    in_stall_o  = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        pc_d    = '0;
        state_d = sts_i.is_read ? ST_RDMEM : ST_ISSUE;
      end
      ST_ISSUE: begin
        cmd_o.rf_rd = 1'b1;
        state_d     = ST_EX1;
      end
      ST_EX1: begin
        cmd_o.ex1 = 1'b1;
        state_d   = ST_EX2;
      end
      ST_EX2: begin
        cmd_o.ex2 = 1'b1;
        state_d   = ST_EX3;
      end
      ST_EX3: begin
        cmd_o.ex3 = 1'b1;
        if (pc_q == PROG_LAST) begin
          state_d = ST_DONE;
        end else begin
          pc_d    = pc_q + 1'b1;
          state_d = ST_ISSUE;
        end
      end
      ST_RDMEM: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) pc_q <= PROG_LAST)
    else $error("program counter past end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EX3 && pc_q == PROG_LAST) |=> state_q == ST_DONE)
    else $error("program end not followed by done");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && slot_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished item not presented");

endmodule

// ===== tb/sv/ring_degree4_base_inverse_chk.sv =====
// checker for the degree-4 base inversion block: predicts each result and compares it
module ring_degree4_base_inverse_chk (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  rdbi_pkg::rdbi_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  rdbi_pkg::rdbi_out_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import rdbi_pkg::*;

  localparam longint QQ = 3457;

  logic [11:0] leaf_mem [LEAF_COUNT][4];
  logic        batch_bad;
  rdbi_out_t   leaf_results [$];

  function automatic longint unsigned fold(longint v);
    longint r;
    r = v % QQ;
    if (r < 0) r += QQ;
    return r;
  endfunction

  function automatic longint unsigned mulq(longint x, longint y);
    return fold(fold(x) * fold(y));
  endfunction

  function automatic logic [11:0] centered(longint v);
    longint r;
    r = fold(v);
    if (r > QQ / 2) r -= QQ;
    return r[11:0];
  endfunction

  function automatic rdbi_out_t invert_leaf(rdbi_in_t it);
    rdbi_out_t o;
    longint a0, a1, a2, a3, lam, t0, t1, det, inv, b;
    longint n [4];
    logic [11:0] r [4];
    int e;
    a0 = fold(longint'(it.coef_zero));
    a1 = fold(longint'(it.coef_one));
    a2 = fold(longint'(it.coef_two));
    a3 = fold(longint'(it.coef_three));
    lam = mulq(longint'(it.root_mont), RINV);
    t0 = fold(mulq(a0, a0) + mulq(lam, fold(mulq(a2, a2) - 2 * mulq(a1, a3))));
    t1 = fold(mulq(a1, a1) + mulq(lam, mulq(a3, a3)) - 2 * mulq(a0, a2));
    det = fold(mulq(t0, t0) - mulq(lam, mulq(t1, t1)));
    inv = 1;
    b = det;
    for (e = 0; e < 12; e++) begin
      if (((QQ - 2) >> e) & 1) inv = mulq(inv, b);
      b = mulq(b, b);
    end
    n[0] = fold(mulq(a0, t0) + mulq(lam, mulq(a2, t1)));
    n[1] = fold(-mulq(lam, mulq(a3, t1)) - mulq(a1, t0));
    n[2] = fold(mulq(a2, t0) + mulq(a0, t1));
    n[3] = fold(-mulq(a1, t1) - mulq(a3, t0));
    for (e = 0; e < 4; e++) r[e] = centered(mulq(mulq(n[e], inv), SCALE));
    if (it.leaf_index == 0) batch_bad = 1'b0;
    o.leaf_failed = (det == 0);
    if (det == 0) batch_bad = 1'b1;
    if (it.leaf_index < LEAF_COUNT)
      for (e = 0; e < 4; e++) leaf_mem[it.leaf_index][e] = r[e];
    o.out_zero = batch_bad ? '0 : r[0];
    o.out_one = batch_bad ? '0 : r[1];
    o.out_two = batch_bad ? '0 : r[2];
    o.out_three = batch_bad ? '0 : r[3];
    o.batch_failed = batch_bad;
    return o;
  endfunction

  function automatic rdbi_out_t read_leaf(rdbi_in_t it);
    rdbi_out_t o;
    logic [11:0] r [4];
    int e;
    for (e = 0; e < 4; e++)
      r[e] = (it.leaf_index < LEAF_COUNT) ? leaf_mem[it.leaf_index][e] : 12'd0;
    o.out_zero = batch_bad ? '0 : r[0];
    o.out_one = batch_bad ? '0 : r[1];
    o.out_two = batch_bad ? '0 : r[2];
    o.out_three = batch_bad ? '0 : r[3];
    o.leaf_failed = 1'b0;
    o.batch_failed = batch_bad;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rdbi_out_t want;
    if (!rst_ni) begin
      batch_bad = 1'b0;
      fail_count_o = 0;
      leaf_results.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (leaf_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected item: %p", out_data_i);
        end else begin
          want = leaf_results.pop_front();
          if (out_data_i !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: expected %p actual %p", want, out_data_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (rdbi_cmd_e'(in_data_i.command) == CMD_INVERT)
          leaf_results.push_back(invert_leaf(in_data_i));
        else
          leaf_results.push_back(read_leaf(in_data_i));
      end
      pending_o = leaf_results.size();
    end
  end

endmodule

// ===== tb/sv/ring_degree4_base_inverse_tb.sv =====
// testbench top for the degree-4 base inversion block: stimulus and verdict
module ring_degree4_base_inverse_tb;
  import rdbi_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  rdbi_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  rdbi_out_t out_data_o;
  int        fail_count;
  int        pending;
  int        in_idle_pct = 7;
  int        out_idle_pct = 82;
  int        hold_off = 0;
  int        cycle_count = 0;
  bit        written [LEAF_COUNT];

  ring_degree4_base_inverse dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  ring_degree4_base_inverse_chk chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stall, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      out_stall_i <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < out_idle_pct);
    end
  end

  function automatic logic signed [15:0] rand_coef();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(6914)) - 3457);
      3: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(rdbi_cmd_e cmd, logic [7:0] idx, logic signed [15:0] c0,
                      logic signed [15:0] c1, logic signed [15:0] c2,
                      logic signed [15:0] c3, logic [11:0] lam);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_data_i <= '{command: cmd, leaf_index: idx, coef_zero: c0, coef_one: c1,
                   coef_two: c2, coef_three: c3, root_mont: lam};
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    if (cmd == CMD_INVERT && idx < LEAF_COUNT) written[idx] = 1'b1;
  endtask

  task automatic random_item();
    logic [7:0] idx;
    if ($urandom_range(3) == 0) begin
      idx = 8'($urandom_range(LEAF_COUNT - 1));
      if (!written[idx]) idx = 8'd0;
      if (written[idx]) begin
        send(CMD_READ, idx, 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom), 12'($urandom));
        return;
      end
    end
    idx = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(191));
    if ($urandom_range(15) == 0)
      send(CMD_INVERT, idx, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 12'($urandom_range(3456)));
    else
      send(CMD_INVERT, idx, rand_coef(), rand_coef(), rand_coef(), rand_coef(),
           12'($urandom_range(3456)));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: extremes, zero determinant, batch restart, out of range slots
    send(CMD_INVERT, 8'd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 12'd0);
    send(CMD_INVERT, 8'd191, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 12'd3456);
    send(CMD_INVERT, 8'd5, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 12'hfff);
    send(CMD_INVERT, 8'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 12'd1);
    send(CMD_READ, 8'd191, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 12'd0);
    send(CMD_READ, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 12'd0);
    send(CMD_INVERT, 8'd200, 16'sd3, 16'sd5, -16'sd7, 16'sd11, 12'd1000);
    send(CMD_READ, 8'd255, 16'shffff, 16'shffff, 16'shffff, 16'shffff, 12'hfff);
    send(CMD_INVERT, 8'd0, 16'sd2, 16'sd0, 16'sd1, 16'sd0, 12'd2285);
    send(CMD_READ, 8'd5, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 12'd0);
    send(CMD_INVERT, 8'd2, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 12'd1);
    send(CMD_READ, 8'd2, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 12'd0);
    drain();
    // long receiver hold-off while the sender keeps offering
    hold_off = 1500;
    repeat (6) random_item();
    drain();
    repeat (330) random_item();
    drain();
    in_idle_pct = 82;
    out_idle_pct = 7;
    repeat (350) random_item();
    drain();
    in_idle_pct = 0;
    out_idle_pct = 0;
    repeat (350) random_item();
    drain();
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== ring_degree4_base_inverse.f =====
hw/rtl/rdbi_pkg.sv
hw/rtl/rdbi_dp.sv
hw/rtl/rdbi_ctrl.sv
hw/rtl/ring_degree4_base_inverse.sv
tb/sv/ring_degree4_base_inverse_chk.sv
tb/sv/ring_degree4_base_inverse_tb.sv
